>>> rtl/stg_pkg.sv
// shared types, constants and the quarter-wave sine table for the tone generator
package stg_pkg;

	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	localparam int INC_BITS  = 32;
	localparam int AMP_BITS  = 15;
	localparam int GAIN_BITS = 16;
	localparam int SINE_BITS = 15;
	localparam int AG_BITS   = AMP_BITS + GAIN_BITS;
	localparam int MAG_BITS  = AG_BITS + SINE_BITS;
	localparam int OUT_SHIFT = 46 - SAMPLE_BITS;
	localparam int RND_BITS  = MAG_BITS + 1 - OUT_SHIFT;

	// tuning word sits at the top of the accumulator
	localparam int INC_SHIFT_UP = (PHASE_BITS >= INC_BITS) ? PHASE_BITS - INC_BITS : 0;
	localparam int INC_SHIFT_DN = (PHASE_BITS >= INC_BITS) ? 0 : INC_BITS - PHASE_BITS;

	localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
	localparam int QTR_LEN  = 1 << QTR_BITS;
	localparam int POS_BITS = QTR_BITS + 1;

	localparam logic [GAIN_BITS-1:0] GAIN_FULL = GAIN_BITS'(32768);

	localparam logic [RND_BITS-1:0] LIM_POS = RND_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic [RND_BITS-1:0] LIM_NEG = RND_BITS'(1 << (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_INC  = 2'd2;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [INC_BITS-1:0]  RST_PHASE_INC = 32'd0;
	localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE = 15'd3277;
	localparam logic [GAIN_BITS-1:0] RST_FADE_INC  = 16'd68;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef struct packed {
		logic [GAIN_BITS-1:0] target_gain;
		logic                 end_of_period;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_of_period;
	} out_item_t;

	// work handed from the front to the back
	typedef struct packed {
		logic [GAIN_BITS-1:0]       gain;
		logic [TABLE_ADDR_BITS-1:0] phase_idx;
		logic                       last;
	} mid_item_t;

	typedef struct packed {
		logic [INC_BITS-1:0]  phase_increment;
		logic [AMP_BITS-1:0]  amplitude;
		logic [GAIN_BITS-1:0] fade_increment;
	} cfg_t;

	typedef logic [SINE_BITS-1:0] sine_rom_t [0:QTR_LEN];

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// round(32767 * sin(pi/2 * k / QTR_LEN)) from a Q30 Horner series, evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		for (int k = 0; k <= QTR_LEN; k++) begin
			x   = (HALF_PI_Q30 * 64'(k)) / QTR_LEN;
			x2  = (x * x) >> 30;
			acc = Q30_ONE;
			t   = ((x2 * acc) >> 30) / 64'd210;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd156;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd110;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd72;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd42;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd20;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			t   = ((x2 * acc) >> 30) / 64'd6;
			acc = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
			s   = (x * acc) >> 30;
			e   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
			rom[k] = (e > 64'd32767) ? SINE_BITS'(32767) : e[SINE_BITS-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/stg_front.sv
// front end: accepts ticks, ramps the gain and steps the phase accumulator
module stg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  stg_pkg::in_item_t    tick,
	input  stg_pkg::cfg_t        cfg,
	output logic                 mid_push,
	output stg_pkg::mid_item_t   mid_item,
	input  logic                 mid_full
);

	logic [stg_pkg::GAIN_BITS-1:0]  cur_gain_q;
	logic [stg_pkg::PHASE_BITS-1:0] phase_q;
	logic [stg_pkg::PHASE_BITS-1:0] phase_inc;
	logic [stg_pkg::GAIN_BITS-1:0]  target;
	logic [stg_pkg::GAIN_BITS:0]    up_sum;
	logic [stg_pkg::GAIN_BITS-1:0]  down_diff;
	logic [stg_pkg::GAIN_BITS-1:0]  gain_new;

	assign full     = mid_full;
	assign mid_push = push && !mid_full;

	// tuning word aligned to the top of the accumulator
	assign phase_inc = stg_pkg::PHASE_BITS'((64'(cfg.phase_increment) << stg_pkg::INC_SHIFT_UP)
		>> stg_pkg::INC_SHIFT_DN);

	always_comb begin
		target = (tick.target_gain > stg_pkg::GAIN_FULL) ? stg_pkg::GAIN_FULL
			: tick.target_gain;
		up_sum    = {1'b0, cur_gain_q} + {1'b0, cfg.fade_increment};
		down_diff = cur_gain_q - cfg.fade_increment;
		if (cur_gain_q < target) begin
			gain_new = (up_sum < {1'b0, target}) ? up_sum[stg_pkg::GAIN_BITS-1:0] : target;
		end else if (cfg.fade_increment > cur_gain_q) begin
			// step would go below zero, so it lands on the target
			gain_new = target;
		end else begin
			gain_new = (down_diff > target) ? down_diff : target;
		end
	end

	always_comb begin
		mid_item.gain      = gain_new;
		mid_item.phase_idx = phase_q[stg_pkg::PHASE_BITS-1 -: stg_pkg::TABLE_ADDR_BITS];
		mid_item.last      = tick.end_of_period;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gain_q <= '0;
			phase_q    <= '0;
		end else if (mid_push) begin
			cur_gain_q <= gain_new;
			phase_q    <= phase_q + phase_inc;
		end
	end

endmodule

>>> rtl/stg_queue.sv
// short queue that decouples the front end from the sample pipeline
module stg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  stg_pkg::mid_item_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output stg_pkg::mid_item_t rd_data,
	output logic               empty
);

	stg_pkg::mid_item_t             mem_q [stg_pkg::QUEUE_DEPTH];
	logic [stg_pkg::QPTR_BITS-1:0]  wr_ptr_q;
	logic [stg_pkg::QPTR_BITS-1:0]  rd_ptr_q;
	logic [stg_pkg::QCNT_BITS-1:0]  count_q;

	assign full    = (count_q == stg_pkg::QCNT_BITS'(stg_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/stg_back.sv
// back end: sine lookup, gain and level multiplies, rounding, and the result queue
module stg_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [stg_pkg::AMP_BITS-1:0]  amplitude,
	input  stg_pkg::mid_item_t            mid_item,
	input  logic                          mid_empty,
	output logic                          mid_pop,
	input  logic                          pop,
	output logic                          empty,
	output stg_pkg::out_item_t            result
);

	logic                            v_s1, v_s2, v_s3;
	logic [stg_pkg::AG_BITS-1:0]     ag_s1;
	logic [stg_pkg::SINE_BITS-1:0]   sine_s1;
	logic                            neg_s1, last_s1;
	logic [stg_pkg::MAG_BITS-1:0]    mag_s2;
	logic                            neg_s2, last_s2;
	stg_pkg::out_item_t              res_s3;

	logic                            en;
	logic                            out_full;
	logic                            out_push;
	logic [stg_pkg::QTR_BITS-1:0]    off;
	logic [1:0]                      quad;
	logic [stg_pkg::POS_BITS-1:0]    pos;
	logic [stg_pkg::MAG_BITS:0]      rnd_sum;
	logic [stg_pkg::RND_BITS-1:0]    rnd;
	logic [stg_pkg::SAMPLE_BITS-1:0] rnd_neg;
	logic signed [stg_pkg::SAMPLE_BITS-1:0] sat;

	stg_pkg::out_item_t              oq_q [stg_pkg::QUEUE_DEPTH];
	logic [stg_pkg::QPTR_BITS-1:0]   oq_wr_q;
	logic [stg_pkg::QPTR_BITS-1:0]   oq_rd_q;
	logic [stg_pkg::QCNT_BITS-1:0]   oq_cnt_q;
	logic                            out_pop;

	// whole pipeline holds only when the last stage cannot drain
	assign en      = !(v_s3 && out_full);
	assign mid_pop = en && !mid_empty;
	assign out_push = v_s3 && !out_full;

	// quarter-wave addressing: odd quadrants mirror, upper half negates
	always_comb begin
		quad = mid_item.phase_idx[stg_pkg::TABLE_ADDR_BITS-1 -: 2];
		off  = mid_item.phase_idx[stg_pkg::QTR_BITS-1:0];
		pos  = quad[0] ? stg_pkg::POS_BITS'(stg_pkg::QTR_LEN) - {1'b0, off} : {1'b0, off};
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		rnd_sum = {1'b0, mag_s2} + (stg_pkg::MAG_BITS+1)'(64'd1 << (stg_pkg::OUT_SHIFT - 1));
		rnd     = rnd_sum[stg_pkg::MAG_BITS -: stg_pkg::RND_BITS];
		rnd_neg = '0 - rnd[stg_pkg::SAMPLE_BITS-1:0];
		if (neg_s2) begin
			sat = (rnd > stg_pkg::LIM_NEG) ? stg_pkg::SAMPLE_MIN : rnd_neg;
		end else begin
			sat = (rnd > stg_pkg::LIM_POS) ? stg_pkg::SAMPLE_MAX
				: rnd[stg_pkg::SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ag_s1   <= stg_pkg::AG_BITS'(amplitude) * stg_pkg::AG_BITS'(mid_item.gain);
			sine_s1 <= stg_pkg::SINE_ROM[pos];
			neg_s1  <= quad[1];
			last_s1 <= mid_item.last;
			mag_s2  <= stg_pkg::MAG_BITS'(ag_s1) * stg_pkg::MAG_BITS'(sine_s1);
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
			res_s3.sample         <= sat;
			res_s3.last_of_period <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= !mid_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// result queue
	assign out_full = (oq_cnt_q == stg_pkg::QCNT_BITS'(stg_pkg::QUEUE_DEPTH));
	assign empty    = (oq_cnt_q == '0);
	assign result   = oq_q[oq_rd_q];
	assign out_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (out_push) begin
			oq_q[oq_wr_q] <= res_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (out_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({out_push, out_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/sine_tone_generator_with_fade.sv
// top level of the sine tone generator with linear gain fade
//
// Each input item is one sample tick carrying a target gain and an end-of-period
// mark. The gain first moves toward the target by at most fade_increment, the
// sample is amplitude * gain * sin(phase) rounded and saturated, then the phase
// accumulator advances by phase_increment.
// Input: an item is taken when push is high and full is low.
// Output: the oldest result sits on result while empty is low; pop takes it.
// Configuration: cfg_index 0 = phase_increment, 1 = amplitude, 2 = fade_increment;
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// The path from a taken item to its result runs through the front queue, table
// lookup and gain multiply, level multiply, round and saturate, and the result queue.
// Throughput: one item per cycle while full is low; the front gain/phase loop never stalls it.
// Reset clears gain, phase, queues and pipeline, and loads register defaults.
// When the receiver stalls, the result queue fills, the pipeline holds, and the
// front queue fills until full rises; nothing is dropped.
module sine_tone_generator_with_fade (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  stg_pkg::in_item_t                   tick,
	output logic                                empty,
	input  logic                                pop,
	output stg_pkg::out_item_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [stg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	stg_pkg::cfg_t      cfg_q;
	logic               mid_push;
	logic               mid_full;
	logic               mid_pop;
	logic               mid_empty;
	stg_pkg::mid_item_t mid_wr;
	stg_pkg::mid_item_t mid_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= stg_pkg::RST_PHASE_INC;
			cfg_q.amplitude       <= stg_pkg::RST_AMPLITUDE;
			cfg_q.fade_increment  <= stg_pkg::RST_FADE_INC;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stg_pkg::CFG_PHASE_INC: cfg_q.phase_increment <= cfg_data[stg_pkg::INC_BITS-1:0];
				stg_pkg::CFG_AMPLITUDE: cfg_q.amplitude       <= cfg_data[stg_pkg::AMP_BITS-1:0];
				stg_pkg::CFG_FADE_INC:  cfg_q.fade_increment  <= cfg_data[stg_pkg::GAIN_BITS-1:0];
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	stg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.tick     (tick),
		.cfg      (cfg_q),
		.mid_push (mid_push),
		.mid_item (mid_wr),
		.mid_full (mid_full)
	);

	stg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty)
	);

	stg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (cfg_q.amplitude),
		.mid_item  (mid_rd),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
